>>> rtl/sma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants of the simple moving average block.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int unsigned CFG_W      = 9;
    localparam int unsigned IO_W       = 32;
    localparam logic [CFG_W-1:0] WIN_RESET = 9'd20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [IO_W-1:0] price_sample;
        logic                   series_end;
    } t_sma_in;

    typedef struct packed {
        logic signed [IO_W-1:0] window_average;
        logic                   final_average;
    } t_sma_out;

endpackage

>>> rtl/sma_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_stream_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface sma_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> rtl/simple_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_moving_average
// Moving average of signed Q16.16 price samples over a configurable window.
// ----------------------------------------------------------------------------
// Channels: i_in takes one price sample with a series end flag per item,
// o_out gives one average item per sample once the window is full. The user
// must write the window length through i_cfg_we / i_cfg_wdata only while
// idle; the block does not enforce it. A write also starts a new series.
// A window of zero gives no items. An accepted item with a result passes
// through S_LOAD, S_PREP, S_DIV and S_OUT before its average is in the
// output register. The average is formed by a bit-serial restoring divider
// that takes one quotient bit per cycle over the SUM_W-bit window sum; no new
// item is accepted until the block is back in S_IDLE. An item without a result
// returns from S_LOAD to S_IDLE, or stays in S_IDLE with a window of zero.
// Reset (synchronous, active low) sets the window to 20 and empties the
// series; ring contents stay undefined and are only read once written.
// A stalled receiver holds the result in the output register while the
// next item is accepted and processed; that item waits before the output
// register until the register is taken.
// ----------------------------------------------------------------------------
module simple_moving_average #(
    parameter int unsigned MAX_WINDOW   = 256,
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sma_pkg::CFG_W-1:0]  i_cfg_wdata,
    sma_stream_if.sink                 i_in,
    sma_stream_if.source               o_out
);
    import sma_pkg::*;

    localparam int unsigned PTR_W = $clog2(MAX_WINDOW);
    localparam int unsigned WMAX  = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
    localparam int unsigned SUM_W = SAMPLE_WIDTH + $clog2(WMAX + 1);
    localparam int unsigned EXT_W = SUM_W - SAMPLE_WIDTH;
    localparam int unsigned CNT_W = $clog2(SUM_W);
    localparam int unsigned AW    = ((PTR_W > CFG_W) ? PTR_W : CFG_W) + 1;
    localparam logic [CFG_W-1:0] MAX_W9  = CFG_W'(MAX_WINDOW);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(MAX_WINDOW - 1);

    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_win, n_win;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [CFG_W-1:0]        r_fill, n_fill;
    logic [PTR_W-1:0]        r_ptr, n_ptr;
    logic                    r_ov, n_ov;

    logic [SAMPLE_WIDTH-1:0] r_x, n_x;
    logic                    r_last, n_last;
    logic                    r_neg, n_neg;
    logic [SUM_W-1:0]        r_dq, n_dq;
    logic [CFG_W-1:0]        r_rem, n_rem;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    t_sma_out                r_out, n_out;

    logic [SAMPLE_WIDTH-1:0] r_ring [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] r_rd;
    logic                    ring_re, ring_we;
    logic [PTR_W-1:0]        rd_addr;

    logic [CFG_W-1:0]        win;
    logic [AW-1:0]           a_ptr, a_win, a_old;
    logic                    full, has_res, out_free;
    logic [CFG_W:0]          fill_inc;
    logic [SUM_W-1:0]        x_ext, old_ext, q_sgn;
    logic [CFG_W:0]          rem_sh;
    logic                    rem_ge;

    // window saturated to the ring depth
    assign win = ({23'd0, r_win} > MAX_WINDOW) ? MAX_W9 : r_win;

    // ring slot leaving the window
    assign a_ptr   = AW'(r_ptr);
    assign a_win   = AW'(win);
    assign a_old   = (a_ptr >= a_win) ? (a_ptr - a_win) : (a_ptr + AW'(MAX_WINDOW) - a_win);
    assign rd_addr = a_old[PTR_W-1:0];

    assign full     = (r_fill >= win);
    assign fill_inc = {1'b0, r_fill} + (CFG_W + 1)'(1);
    assign has_res  = full || (fill_inc == {1'b0, win});
    assign x_ext    = {{EXT_W{r_x[SAMPLE_WIDTH-1]}}, r_x};
    assign old_ext  = full ? {{EXT_W{r_rd[SAMPLE_WIDTH-1]}}, r_rd} : '0;

    assign rem_sh = {r_rem, r_dq[SUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, win});
    assign q_sgn  = r_neg ? (~r_dq + SUM_W'(1)) : r_dq;

    assign out_free    = !r_ov || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_ptr] <= r_x;
        end
        if (ring_re) begin
            r_rd <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_win   <= WIN_RESET;
            r_sum   <= '0;
            r_fill  <= '0;
            r_ptr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_win   <= n_win;
            r_sum   <= n_sum;
            r_fill  <= n_fill;
            r_ptr   <= n_ptr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_last <= n_last;
        r_neg  <= n_neg;
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_win   = r_win;
        n_sum   = r_sum;
        n_fill  = r_fill;
        n_ptr   = r_ptr;
        n_ov    = r_ov;
        n_x     = r_x;
        n_last  = r_last;
        n_neg   = r_neg;
        n_dq    = r_dq;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_out   = r_out;
        ring_re = 1'b0;
        ring_we = 1'b0;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_x    = SAMPLE_WIDTH'($unsigned(i_in.data.price_sample));
                    n_last = i_in.data.series_end;
                    if (win == '0) begin
                        if (i_in.data.series_end) begin
                            n_sum  = '0;
                            n_fill = '0;
                            n_ptr  = '0;
                        end
                    end else begin
                        ring_re = 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                ring_we = 1'b1;
                n_sum   = r_sum + x_ext - old_ext;
                n_fill  = full ? r_fill : fill_inc[CFG_W-1:0];
                n_ptr   = (r_ptr == PTR_TOP) ? '0 : (r_ptr + PTR_W'(1));
                if (has_res) begin
                    n_state = S_PREP;
                end else begin
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_sum  = '0;
                        n_fill = '0;
                        n_ptr  = '0;
                    end
                end
            end
            S_PREP: begin
                n_neg   = r_sum[SUM_W-1];
                n_dq    = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
                if (r_last) begin
                    n_sum  = '0;
                    n_fill = '0;
                    n_ptr  = '0;
                end
            end
            S_DIV: begin
                // one quotient bit per cycle
                n_rem = rem_ge ? CFG_W'(rem_sh - {1'b0, win}) : rem_sh[CFG_W-1:0];
                n_dq  = {r_dq[SUM_W-2:0], rem_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out.window_average = $signed(IO_W'(q_sgn[SAMPLE_WIDTH-1:0]));
                    n_out.final_average  = r_last;
                    n_ov                 = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_win  = i_cfg_wdata;
            n_sum  = '0;
            n_fill = '0;
            n_ptr  = '0;
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the simple moving average block.
// ----------------------------------------------------------------------------
// A directed table covers the reset window, window zero, window one, field
// extremes, truncation toward zero, short series and window saturation. It is
// followed by random phases of well-formed price series with random content
// and some broken series, under several window settings and idle patterns.
// Every accepted average is checked against the table's expected value or an in-bench running-sum model.
// ----------------------------------------------------------------------------
module tb;
    import sma_pkg::*;

    localparam int MAX_WIN     = 256;
    localparam int SETTLE      = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int STUCK_LIMIT = 4000;
    localparam int DIR_ROWS    = 22;
    localparam int MAX_SHOWN   = 10;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_AVG
    } t_check;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } t_idle;

    typedef struct packed {
        bit             cfg_write;
        logic [CFG_W-1:0] cfg_value;
        t_sma_in        item;
        t_check         check;
        t_sma_out       want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    sma_stream_if #(.T(t_sma_in))  in_if ();
    sma_stream_if #(.T(t_sma_out)) out_if ();

    simple_moving_average dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // running-sum model of the block
    logic [CFG_W-1:0]       win_len  = WIN_RESET;
    logic signed [IO_W-1:0] price_ring [MAX_WIN];
    longint                 win_sum  = 0;
    logic [CFG_W-1:0]       fill_cnt = '0;
    logic [7:0]             ring_ptr = '0;

    t_sma_out pending_averages [$];
    int       fail_count  = 0;
    bit       src_gaps    = 1'b0;
    bit       snk_stall   = 1'b0;
    int       idle_pct    = 0;
    logic     hold_req    = 1'b0;
    bit       hold_taken  = 1'b0;
    int       stuck_cycles = 0;

    t_row price_rows [DIR_ROWS] = '{
        '{1'b0, 9'd0,   '{32'sd12345, 1'b1},       CHK_NONE,  '{32'sd0, 1'b0}},
        '{1'b1, 9'd0,   '{32'sh7fffffff, 1'b0},    CHK_NONE,  '{32'sd0, 1'b0}},
        '{1'b0, 9'd0,   '{32'sh80000000, 1'b1},    CHK_NONE,  '{32'sd0, 1'b0}},
        '{1'b1, 9'd1,   '{32'sh7fffffff, 1'b0},    CHK_AVG,   '{32'sh7fffffff, 1'b0}},
        '{1'b0, 9'd0,   '{32'sh80000000, 1'b1},    CHK_AVG,   '{32'sh80000000, 1'b1}},
        '{1'b1, 9'd2,   '{-32'sd3, 1'b0},          CHK_NONE,  '{32'sd0, 1'b0}},
        '{1'b0, 9'd0,   '{32'sd0, 1'b0},           CHK_AVG,   '{-32'sd1, 1'b0}},
        '{1'b0, 9'd0,   '{32'sh7fffffff, 1'b0},    CHK_AVG,   '{32'sh3fffffff, 1'b0}},
        '{1'b0, 9'd0,   '{32'sh7fffffff, 1'b0},    CHK_AVG,   '{32'sh7fffffff, 1'b0}},
        '{1'b0, 9'd0,   '{32'sh80000000, 1'b0},    CHK_AVG,   '{32'sd0, 1'b0}},
        '{1'b0, 9'd0,   '{32'sh80000000, 1'b0},    CHK_AVG,   '{32'sh80000000, 1'b0}},
        '{1'b0, 9'd0,   '{-32'sd1, 1'b1},          CHK_AVG,   '{32'shc0000000, 1'b1}},
        '{1'b0, 9'd0,   '{32'sd5, 1'b1},           CHK_NONE,  '{32'sd0, 1'b0}},
        '{1'b0, 9'd0,   '{32'sd7, 1'b0},           CHK_NONE,  '{32'sd0, 1'b0}},
        '{1'b0, 9'd0,   '{32'sd9, 1'b1},           CHK_AVG,   '{32'sd8, 1'b1}},
        '{1'b1, 9'd3,   '{32'sd1, 1'b0},           CHK_NONE,  '{32'sd0, 1'b0}},
        '{1'b0, 9'd0,   '{32'sd2, 1'b0},           CHK_NONE,  '{32'sd0, 1'b0}},
        '{1'b0, 9'd0,   '{-32'sd7, 1'b1},          CHK_AVG,   '{-32'sd1, 1'b1}},
        '{1'b1, 9'd300, '{32'sd5, 1'b1},           CHK_NONE,  '{32'sd0, 1'b0}},
        '{1'b1, 9'd2,   '{32'sd100, 1'b0},         CHK_MODEL, '{32'sd0, 1'b0}},
        '{1'b0, 9'd0,   '{-32'sd55, 1'b0},         CHK_MODEL, '{32'sd0, 1'b0}},
        '{1'b0, 9'd0,   '{32'sh12345678, 1'b1},    CHK_MODEL, '{32'sd0, 1'b0}}
    };

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic void restart_series();
        win_sum  = 0;
        fill_cnt = '0;
        ring_ptr = '0;
    endfunction

    function automatic bit advance_average(input t_sma_in item, output t_sma_out res);
        int unsigned span;
        logic [7:0]  oldest;
        bit          produced;
        produced = 1'b0;
        res      = '0;
        span     = (win_len > MAX_WIN) ? MAX_WIN : win_len;
        if (span != 0) begin
            if (fill_cnt >= span) begin
                oldest  = ring_ptr - 8'(span);
                win_sum = win_sum - longint'(price_ring[oldest]);
            end else begin
                fill_cnt = fill_cnt + 1'b1;
            end
            win_sum              = win_sum + longint'(item.price_sample);
            price_ring[ring_ptr] = item.price_sample;
            ring_ptr             = ring_ptr + 8'd1;
            if (fill_cnt >= span) begin
                res.window_average = IO_W'(win_sum / longint'(span));
                res.final_average  = item.series_end;
                produced           = 1'b1;
            end
        end
        if (item.series_end)
            restart_series();
        return produced;
    endfunction

    function automatic t_sma_in random_price_item(input bit last);
        t_sma_in item;
        int      near_zero;
        near_zero = $urandom_range(0, 200);
        case ($urandom_range(0, 7))
            0: item.price_sample = 32'sh7fffffff;
            1: item.price_sample = 32'sh80000000;
            2: item.price_sample = IO_W'(near_zero - 100);
            default: item.price_sample = $urandom;
        endcase
        item.series_end = last;
        return item;
    endfunction

    task automatic flag_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%s", msg);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_len = value;
        restart_series();
    endtask

    task automatic send_item(input t_sma_in item, input t_check check, input t_sma_out want);
        t_sma_out model_res;
        bit       model_has;
        while (src_gaps && $urandom_range(0, 99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= item;
        do @(posedge i_clk); while (!in_if.ready);
        model_has = advance_average(item, model_res);
        case (check)
            CHK_MODEL: if (model_has) pending_averages.push_back(model_res);
            CHK_AVG:   pending_averages.push_back(want);
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] win, input int n_items,
                             input t_idle mode, input bit one_series, input bit with_hold);
        int      span;
        int      len;
        int      sent;
        int      k;
        t_sma_in item;
        write_window(win);
        if (with_hold)
            hold_req <= 1'b1;
        src_gaps  = (mode == IDLE_SRC) || (mode == IDLE_BOTH);
        snk_stall = (mode == IDLE_SNK) || (mode == IDLE_BOTH);
        idle_pct  = (mode == IDLE_BOTH) ? 31 : 46;
        span      = (win > MAX_WIN) ? MAX_WIN : win;
        sent      = 0;
        while (sent < n_items) begin
            if (one_series)
                len = n_items;
            else if ($urandom_range(0, 3) != 0)
                len = span + $urandom_range(0, 2 * span + 3);
            else
                len = $urandom_range(1, span + 1);
            for (k = 0; k < len && sent < n_items; k++) begin
                item = random_price_item(k == len - 1);
                // broken series
                if (!one_series && $urandom_range(0, 49) == 0)
                    item.series_end = ~item.series_end;
                send_item(item, CHK_MODEL, '0);
                sent++;
            end
        end
    endtask

    // receiver
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_taken = 1'b1;
            end else begin
                out_if.ready <= !(snk_stall && $urandom_range(0, 99) < idle_pct);
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_sma_out want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_averages.size() == 0) begin
                flag_mismatch($sformatf("unexpected item: average %0d final %0b",
                    out_if.data.window_average, out_if.data.final_average));
            end else begin
                want = pending_averages.pop_front();
                if (out_if.data.window_average !== want.window_average)
                    flag_mismatch($sformatf("window_average: expected %0d, got %0d",
                        want.window_average, out_if.data.window_average));
                if (out_if.data.final_average !== want.final_average)
                    flag_mismatch($sformatf("final_average: expected %0b, got %0b",
                        want.final_average, out_if.data.final_average));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        int p;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIR_ROWS; r++) begin
            if (price_rows[r].cfg_write)
                write_window(price_rows[r].cfg_value);
            send_item(price_rows[r].item, price_rows[r].check, price_rows[r].want);
        end

        run_phase(9'd20, 40, IDLE_NONE, 1'b0, 1'b0);
        run_phase(9'd1, 30, IDLE_SRC, 1'b0, 1'b0);
        run_phase(9'd0, 20, IDLE_SNK, 1'b0, 1'b0);
        // long receiver hold while the sender keeps offering
        run_phase(9'd4, 60, IDLE_NONE, 1'b0, 1'b1);
        run_phase(CFG_W'($urandom_range(2, 8)), 50, IDLE_BOTH, 1'b0, 1'b0);
        // ring pointer wraps inside one series at the saturated window
        run_phase(9'd511, 260, IDLE_BOTH, 1'b1, 1'b0);
        for (p = 0; p < 2; p++)
            run_phase(CFG_W'($urandom_range(1, 40)), 20, t_idle'($urandom_range(0, 3)),
                      1'b0, 1'b0);

        wait_drained();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sma_pkg.sv
rtl/sma_stream_if.sv
rtl/simple_moving_average.sv
sim/tb.sv
